@@ hw/rtl/ellp_pkg.sv @@
// shared types and constants of the dense to ellpack packer
package ellp_pkg;

  localparam int VALUE_W   = 32;
  localparam int COL_W     = 6;
  localparam int WIDTH_W   = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W    = VALUE_W + COL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  typedef struct packed {
    logic               valid;
    logic               refused;
    logic               row_last;
    logic               last;
    logic [WIDTH_W-1:0] width;
  } fetch_tag_t;

endpackage

@@ hw/rtl/dense_to_ell_packer.sv @@
// top level of the dense to ellpack packer
//
// a dense matrix is loaded in row-major order, one element per item, and
// read back in ellpack form, one slot per item. an item is taken at a
// rising edge with start high and busy low; busy stays low, so one item
// can be given in every cycle of any kind.
// op start clears the cursors, op load packs one element, op fetch reads
// the next slot. loads and starts give no result. a fetch gives exactly
// one result, shown for one cycle with strobe high, in the cycle after it
// was taken: one read of the packed memory and of the row count memory.
// status high marks a refused fetch (loading not done, past the end, or
// width zero) with every other field zero.
// row_count and column_count are written on the cfg channel, which is
// always ready; write them only while no result is pending.
// synchronous reset clears the cursors and sets both dimensions to one;
// the memories are not cleared. the receiver cannot stall the results.
module dense_to_ell_packer import ellp_pkg::*;
  #(parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64)
  (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic [VALUE_W-1:0]   value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 strobe,
  output logic [VALUE_W-1:0]   packed_value,
  output logic [COL_W-1:0]     column_index,
  output logic [WIDTH_W-1:0]   ell_width,
  output logic                 row_last,
  output logic                 last,
  output logic                 status
);

  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

  logic              accept;
  logic              pk_we, pk_re, nz_we, nz_re;
  logic [AW-1:0]     pk_waddr, pk_raddr;
  logic [SLOT_W-1:0] pk_wdata, pk_rdata;
  logic [RW-1:0]     nz_waddr, nz_raddr;
  logic [CCW-1:0]    nz_wdata, nz_rdata;
  fetch_tag_t        tag;
  logic [CCW-1:0]    tag_slot;
  logic              hit;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  ellp_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .value     (value),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pk_we     (pk_we),
    .pk_waddr  (pk_waddr),
    .pk_wdata  (pk_wdata),
    .pk_re     (pk_re),
    .pk_raddr  (pk_raddr),
    .nz_we     (nz_we),
    .nz_waddr  (nz_waddr),
    .nz_wdata  (nz_wdata),
    .nz_re     (nz_re),
    .nz_raddr  (nz_raddr),
    .tag       (tag),
    .tag_slot  (tag_slot)
  );

  ellp_ram #(.DEPTH(MAX_ROWS * MAX_COLS), .WIDTH(SLOT_W)) u_packed (
    .clk   (clk),
    .we    (pk_we),
    .waddr (pk_waddr),
    .wdata (pk_wdata),
    .re    (pk_re),
    .raddr (pk_raddr),
    .rdata (pk_rdata)
  );

  ellp_ram #(.DEPTH(MAX_ROWS), .WIDTH(CCW)) u_counts (
    .clk   (clk),
    .we    (nz_we),
    .waddr (nz_waddr),
    .wdata (nz_wdata),
    .re    (nz_re),
    .raddr (nz_raddr),
    .rdata (nz_rdata)
  );

  // slots past the row count read as padding
  assign hit          = !tag.refused && (tag_slot < nz_rdata);
  assign strobe       = tag.valid;
  assign packed_value = hit ? pk_rdata[SLOT_W-1:COL_W] : '0;
  assign column_index = hit ? pk_rdata[COL_W-1:0] : '0;
  assign ell_width    = tag.width;
  assign row_last     = tag.row_last;
  assign last         = tag.last;
  assign status       = tag.refused;

endmodule

@@ hw/rtl/ellp_ram.sv @@
// single port write, single port read synchronous memory
module ellp_ram
  #(parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
  (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/ellp_ctrl.sv @@
// load and fetch cursors, configuration registers and memory access issue
module ellp_ctrl import ellp_pkg::*;
  #(parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    localparam int RCW = $clog2(MAX_ROWS + 1),
    localparam int CCW = $clog2(MAX_COLS + 1),
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1)
  (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           op,
  input  logic [VALUE_W-1:0]   value,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 pk_we,
  output logic [AW-1:0]        pk_waddr,
  output logic [SLOT_W-1:0]    pk_wdata,
  output logic                 pk_re,
  output logic [AW-1:0]        pk_raddr,
  output logic                 nz_we,
  output logic [RW-1:0]        nz_waddr,
  output logic [CCW-1:0]       nz_wdata,
  output logic                 nz_re,
  output logic [RW-1:0]        nz_raddr,
  output fetch_tag_t           tag,
  output logic [CCW-1:0]       tag_slot
);

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic [CCW-1:0]   max_nz, max_nz_next;
  logic [CCW-1:0]   running_nz, running_nz_next;
  logic [CCW-1:0]   load_col, load_col_next;
  logic [RCW-1:0]   load_row, load_row_next;
  logic [CCW-1:0]   fetch_slot, fetch_slot_next;
  logic [RCW-1:0]   fetch_row, fetch_row_next;
  fetch_tag_t       tag_next;
  logic [CCW-1:0]   tag_slot_next;

  logic [RCW-1:0]   rows_eff;
  logic [CCW-1:0]   cols_eff;
  logic             load_active;
  logic             nonzero;
  logic [CCW-1:0]   row_total;
  logic [CCW-1:0]   col_inc;
  logic             refused;
  logic             slot_end;
  logic             row_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CFG_W'(1);
      column_count <= CFG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count <= cfg_data;
        CFG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_nz     <= '0;
      running_nz <= '0;
      load_col   <= '0;
      load_row   <= '0;
      fetch_slot <= '0;
      fetch_row  <= '0;
      tag        <= '0;
    end else begin
      max_nz     <= max_nz_next;
      running_nz <= running_nz_next;
      load_col   <= load_col_next;
      load_row   <= load_row_next;
      fetch_slot <= fetch_slot_next;
      fetch_row  <= fetch_row_next;
      tag        <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    tag_slot <= tag_slot_next;
  end

  always_comb begin
    if (row_count == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(row_count);
    end
    if (column_count == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(column_count) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(column_count);
    end

    load_active = load_row < rows_eff;
    nonzero     = value[VALUE_W-2:0] != '0;
    row_total   = nonzero ? running_nz + CCW'(1) : running_nz;
    col_inc     = load_col + CCW'(1);
    refused     = load_active || (fetch_row >= rows_eff) || (max_nz == '0);
    slot_end    = (fetch_slot + CCW'(1)) >= max_nz;
    row_final   = (fetch_row + RCW'(1)) >= rows_eff;

    pk_waddr = AW'(load_row[RW-1:0]) * AW'(MAX_COLS) + AW'(running_nz[CW-1:0]);
    pk_wdata = {value, COL_W'(load_col)};
    pk_raddr = AW'(fetch_row[RW-1:0]) * AW'(MAX_COLS) + AW'(fetch_slot[CW-1:0]);
    nz_waddr = load_row[RW-1:0];
    nz_wdata = row_total;
    nz_raddr = fetch_row[RW-1:0];

    pk_we = 1'b0;
    pk_re = 1'b0;
    nz_we = 1'b0;
    nz_re = 1'b0;

    max_nz_next     = max_nz;
    running_nz_next = running_nz;
    load_col_next   = load_col;
    load_row_next   = load_row;
    fetch_slot_next = fetch_slot;
    fetch_row_next  = fetch_row;
    tag_next        = '0;
    tag_slot_next   = fetch_slot;

    if (accept) begin
      case (op_t'(op))
        OP_START: begin
          max_nz_next     = '0;
          running_nz_next = '0;
          load_col_next   = '0;
          load_row_next   = '0;
          fetch_slot_next = '0;
          fetch_row_next  = '0;
        end
        OP_LOAD: begin
          if (load_active) begin
            pk_we           = nonzero;
            running_nz_next = row_total;
            load_col_next   = col_inc;
            if (col_inc >= cols_eff) begin
              nz_we           = 1'b1;
              running_nz_next = '0;
              load_col_next   = '0;
              load_row_next   = load_row + RCW'(1);
              if (row_total > max_nz) begin
                max_nz_next = row_total;
              end
            end
          end
        end
        OP_FETCH: begin
          tag_next.valid = 1'b1;
          if (refused) begin
            tag_next.refused = 1'b1;
          end else begin
            pk_re             = 1'b1;
            nz_re             = 1'b1;
            tag_next.width    = WIDTH_W'(max_nz);
            tag_next.row_last = slot_end;
            tag_next.last     = slot_end && row_final;
            if (slot_end) begin
              fetch_slot_next = '0;
              fetch_row_next  = fetch_row + RCW'(1);
            end else begin
              fetch_slot_next = fetch_slot + CCW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/ellp_checker.sv @@
// port level checks of the dense to ellpack packer and their binding
module ellp_checker import ellp_pkg::*;
  (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           op,
  input logic                 strobe,
  input logic [VALUE_W-1:0]   packed_value,
  input logic [COL_W-1:0]     column_index,
  input logic [WIDTH_W-1:0]   ell_width,
  input logic                 row_last,
  input logic                 last,
  input logic                 status
);

  // one result right after each fetch item, none otherwise
  a_fetch_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_FETCH) |=> strobe)
    else $error("fetch item gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy && op == OP_FETCH) |=> !strobe)
    else $error("result without fetch item");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> (packed_value == '0 && column_index == '0 &&
                            ell_width == '0 && !row_last && !last))
    else $error("refused fetch with nonzero fields");

  a_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (row_last && !status && ell_width != '0))
    else $error("final slot not at row end");

  a_padding_column: assert property (@(posedge clk) disable iff (rst)
    (strobe && !status && packed_value == '0) |-> column_index == '0)
    else $error("padding slot with nonzero column");

endmodule

bind dense_to_ell_packer ellp_checker u_ellp_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .strobe       (strobe),
  .packed_value (packed_value),
  .column_index (column_index),
  .ell_width    (ell_width),
  .row_last     (row_last),
  .last         (last),
  .status       (status)
);
